// File: rtl/id3df_pkg.sv
`timescale 1ns / 1ps
// shared types, codes and helpers for the id3v2 frame deframer
// no dependencies; used by id3df_csr, id3df_parse and the core top level

package id3df_pkg;

   localparam int BYTE_W = 8;
   localparam int WORD_W = 32;
   localparam int ADDR_W = 5;

   // result roles
   localparam logic [2:0] ROLE_ID      = 3'd0;
   localparam logic [2:0] ROLE_SIZE    = 3'd1;
   localparam logic [2:0] ROLE_FLAGS   = 3'd2;
   localparam logic [2:0] ROLE_ENC     = 3'd3;
   localparam logic [2:0] ROLE_PAYLOAD = 3'd4;
   localparam logic [2:0] ROLE_PAD     = 3'd5;
   localparam logic [2:0] ROLE_TRAIL   = 3'd6;

   // error codes
   localparam logic [1:0] ERR_NONE     = 2'd0;
   localparam logic [1:0] ERR_HEADER   = 2'd1;
   localparam logic [1:0] ERR_PAYLOAD  = 2'd2;

   // register indexes (byte address = 4 * index)
   localparam logic [2:0] REG_ID_BYTES   = 3'd0;
   localparam logic [2:0] REG_SIZE_BYTES = 3'd1;
   localparam logic [2:0] REG_FLAG_BYTES = 3'd2;
   localparam logic [2:0] REG_SYNC_SAFE  = 3'd3;
   localparam logic [2:0] REG_TAG_BYTES  = 3'd4;

   localparam logic [2:0] ID_BYTES_RST   = 3'd4;
   localparam logic [2:0] SIZE_BYTES_RST = 3'd4;
   localparam logic [1:0] FLAG_BYTES_RST = 2'd2;

   localparam logic [7:0] TEXT_MARK = 8'h54;

   typedef struct packed {
      logic [2:0]        ids;
      logic [2:0]        szs;
      logic [1:0]        flg;
      logic              sync_safe;
      logic [WORD_W-1:0] tag;
   } cfg_type;

   typedef struct packed {
      logic [BYTE_W-1:0] byte_in;
      logic              first_byte;
   } item_type;

   typedef struct packed {
      logic [2:0]        role;
      logic [BYTE_W-1:0] byte_out;
      logic [WORD_W-1:0] frame_ident;
      logic [WORD_W-1:0] frame_length;
      logic [BYTE_W-1:0] text_encoding;
      logic              end_of_frame;
      logic [1:0]        error_code;
   } result_type;

   function automatic logic [2:0] clamp_3_4(input logic [2:0] v);
      logic [2:0] r;
      if (v < 3'd3) begin
         r = 3'd3;
      end else if (v > 3'd4) begin
         r = 3'd4;
      end else begin
         r = v;
      end
      return r;
   endfunction

   function automatic logic [1:0] clamp_0_2(input logic [1:0] v);
      logic [1:0] r;
      r = (v > 2'd2) ? 2'd2 : v;
      return r;
   endfunction

endpackage

// File: rtl/id3df_csr.sv
`timescale 1ns / 1ps
// configuration register file with apb-style access
// depends on id3df_pkg; hands the saturated settings to the parser

module id3df_csr (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [id3df_pkg::ADDR_W-1:0] csr_paddr,
   input  logic [31:0]                  csr_pwdata,
   output logic [31:0]                  csr_prdata,
   output logic                         csr_pready,
   output id3df_pkg::cfg_type           cfg
);

   logic [2:0]  id_bytes_ff,   id_bytes_in;
   logic [2:0]  size_bytes_ff, size_bytes_in;
   logic [1:0]  flag_bytes_ff, flag_bytes_in;
   logic        sync_safe_ff,  sync_safe_in;
   logic [31:0] tag_bytes_ff,  tag_bytes_in;
   logic        wr_en;
   logic [2:0]  reg_idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign reg_idx    = csr_paddr[id3df_pkg::ADDR_W-1:2];

   always_comb begin
      id_bytes_in   = id_bytes_ff;
      size_bytes_in = size_bytes_ff;
      flag_bytes_in = flag_bytes_ff;
      sync_safe_in  = sync_safe_ff;
      tag_bytes_in  = tag_bytes_ff;
      if (wr_en) begin
         unique case (reg_idx)
            id3df_pkg::REG_ID_BYTES:   id_bytes_in   = csr_pwdata[2:0];
            id3df_pkg::REG_SIZE_BYTES: size_bytes_in = csr_pwdata[2:0];
            id3df_pkg::REG_FLAG_BYTES: flag_bytes_in = csr_pwdata[1:0];
            id3df_pkg::REG_SYNC_SAFE:  sync_safe_in  = csr_pwdata[0];
            id3df_pkg::REG_TAG_BYTES:  tag_bytes_in  = csr_pwdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         id_bytes_ff   <= id3df_pkg::ID_BYTES_RST;
         size_bytes_ff <= id3df_pkg::SIZE_BYTES_RST;
         flag_bytes_ff <= id3df_pkg::FLAG_BYTES_RST;
         sync_safe_ff  <= 1'b0;
         tag_bytes_ff  <= 32'h0;
      end else begin
         id_bytes_ff   <= id_bytes_in;
         size_bytes_ff <= size_bytes_in;
         flag_bytes_ff <= flag_bytes_in;
         sync_safe_ff  <= sync_safe_in;
         tag_bytes_ff  <= tag_bytes_in;
      end
   end

   always_comb begin
      unique case (reg_idx)
         id3df_pkg::REG_ID_BYTES:   csr_prdata = {29'h0, id_bytes_ff};
         id3df_pkg::REG_SIZE_BYTES: csr_prdata = {29'h0, size_bytes_ff};
         id3df_pkg::REG_FLAG_BYTES: csr_prdata = {30'h0, flag_bytes_ff};
         id3df_pkg::REG_SYNC_SAFE:  csr_prdata = {31'h0, sync_safe_ff};
         id3df_pkg::REG_TAG_BYTES:  csr_prdata = tag_bytes_ff;
         default:                   csr_prdata = 32'h0;
      endcase
   end

   assign cfg.ids       = id3df_pkg::clamp_3_4(id_bytes_ff);
   assign cfg.szs       = id3df_pkg::clamp_3_4(size_bytes_ff);
   assign cfg.flg       = id3df_pkg::clamp_0_2(flag_bytes_ff);
   assign cfg.sync_safe = sync_safe_ff;
   assign cfg.tag       = tag_bytes_ff;

endmodule

// File: rtl/id3df_parse.sv
`timescale 1ns / 1ps
// frame parser: phase, counters and header state, one byte per step
// depends on id3df_pkg; result is combinational, registered by the top level

module id3df_parse (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  id3df_pkg::cfg_type    cfg,
   input  id3df_pkg::item_type   item,
   output id3df_pkg::result_type result
);

   typedef enum logic [2:0] {
      PH_ID, PH_SIZE, PH_FLAGS, PH_ENC, PH_PAYLOAD, PH_PAD, PH_TRAIL
   } phase_type;

   phase_type   phase_ff, phase_in, cur_phase;
   logic [2:0]  fc_ff, fc_in, cur_fc, fc_inc;
   logic [31:0] position_ff, position_in, cur_pos;
   logic [31:0] pl_ff, pl_in, cur_pl, pl_dec;
   logic [31:0] ident_ff, ident_in, cur_ident, ident_shift;
   logic [31:0] flen_ff, flen_in, cur_flen, flen_dec, size_len, close_len;
   logic [7:0]  enc_ff, enc_in, cur_enc, first_char, b;
   logic [32:0] pos33, tag33, pos_hdr33;
   logic [3:0]  hdr_len;
   logic        hdr_over, enc_over, do_close, eof;
   logic [2:0]  role;
   logic [1:0]  err;

   assign b = item.byte_in;

   // restart clears frame state and position
   assign cur_phase = item.first_byte ? PH_ID : phase_ff;
   assign cur_fc    = item.first_byte ? 3'd0  : fc_ff;
   assign cur_pos   = item.first_byte ? 32'h0 : position_ff;
   assign cur_pl    = item.first_byte ? 32'h0 : pl_ff;
   assign cur_ident = item.first_byte ? 32'h0 : ident_ff;
   assign cur_flen  = item.first_byte ? 32'h0 : flen_ff;
   assign cur_enc   = item.first_byte ? 8'h0  : enc_ff;

   assign fc_inc    = cur_fc + 3'd1;
   assign pos33     = {1'b0, cur_pos};
   assign tag33     = {1'b0, cfg.tag};
   assign hdr_len   = {1'b0, cfg.ids} + {1'b0, cfg.szs} + {2'b0, cfg.flg};
   assign pos_hdr33 = pos33 + {29'h0, hdr_len};

   assign ident_shift = {((cur_fc == 3'd0) ? 24'h0 : cur_ident[23:0]), b};
   assign size_len    = cfg.sync_safe ? ({cur_flen[24:0], 7'h0} | {24'h0, b})
                                      : {cur_flen[23:0], b};
   assign close_len   = (cur_phase == PH_SIZE) ? size_len : cur_flen;
   assign first_char  = (cfg.ids == 3'd4) ? cur_ident[31:24] : cur_ident[23:16];
   assign hdr_over    = (pos33 + 33'd1 + {1'b0, close_len}) > tag33;
   // decrement of zero wraps and always overruns the tag
   assign enc_over    = (cur_flen == 32'h0) || ((pos33 + {1'b0, cur_flen}) > tag33);
   assign flen_dec    = cur_flen - 32'd1;
   assign pl_dec      = cur_pl - 32'd1;

   always_comb begin
      phase_in    = cur_phase;
      fc_in       = cur_fc;
      ident_in    = cur_ident;
      flen_in     = cur_flen;
      pl_in       = cur_pl;
      enc_in      = cur_enc;
      position_in = (cur_pos == 32'hFFFF_FFFF) ? cur_pos : cur_pos + 32'd1;
      role        = id3df_pkg::ROLE_TRAIL;
      eof         = 1'b0;
      err         = id3df_pkg::ERR_NONE;
      do_close    = 1'b0;

      unique case (cur_phase)
         PH_ID: begin
            if (cur_fc == 3'd0) begin
               ident_in = 32'h0;
               flen_in  = 32'h0;
               pl_in    = 32'h0;
               enc_in   = 8'h0;
            end
            priority if (cur_fc == 3'd0 && pos33 >= tag33) begin
               phase_in = PH_TRAIL;
            end else if (cur_fc == 3'd0 && pos_hdr33 >= tag33) begin
               err      = id3df_pkg::ERR_HEADER;
               phase_in = PH_TRAIL;
            end else begin
               role     = id3df_pkg::ROLE_ID;
               ident_in = ident_shift;
               fc_in    = fc_inc;
               if (fc_inc >= cfg.ids) begin
                  fc_in    = 3'd0;
                  phase_in = (ident_shift == 32'h0) ? PH_PAD : PH_SIZE;
               end
            end
         end
         PH_SIZE: begin
            role    = id3df_pkg::ROLE_SIZE;
            flen_in = size_len;
            fc_in   = fc_inc;
            if (fc_inc >= cfg.szs) begin
               fc_in = 3'd0;
               if (cfg.flg == 2'd0) begin
                  do_close = 1'b1;
               end else begin
                  phase_in = PH_FLAGS;
               end
            end
         end
         PH_FLAGS: begin
            role  = id3df_pkg::ROLE_FLAGS;
            fc_in = fc_inc;
            if (fc_inc >= {1'b0, cfg.flg}) begin
               fc_in    = 3'd0;
               do_close = 1'b1;
            end
         end
         PH_ENC: begin
            role    = id3df_pkg::ROLE_ENC;
            enc_in  = b;
            flen_in = flen_dec;
            priority if (enc_over) begin
               err      = id3df_pkg::ERR_PAYLOAD;
               phase_in = PH_TRAIL;
            end else if (flen_dec == 32'h0) begin
               eof      = 1'b1;
               phase_in = PH_ID;
               fc_in    = 3'd0;
            end else begin
               pl_in    = flen_dec;
               phase_in = PH_PAYLOAD;
            end
         end
         PH_PAYLOAD: begin
            role  = id3df_pkg::ROLE_PAYLOAD;
            pl_in = pl_dec;
            if (pl_dec == 32'h0) begin
               eof      = 1'b1;
               phase_in = PH_ID;
               fc_in    = 3'd0;
            end
         end
         PH_PAD: begin
            if (pos33 < tag33) begin
               role = id3df_pkg::ROLE_PAD;
            end else begin
               phase_in = PH_TRAIL;
            end
         end
         default: begin
            phase_in = PH_TRAIL;
         end
      endcase

      // end of header: text frames go on to the encoding byte, others to payload or frame end
      if (do_close) begin
         priority if (first_char == id3df_pkg::TEXT_MARK) begin
            phase_in = PH_ENC;
         end else if (hdr_over) begin
            err      = id3df_pkg::ERR_PAYLOAD;
            phase_in = PH_TRAIL;
         end else if (close_len == 32'h0) begin
            eof      = 1'b1;
            phase_in = PH_ID;
            fc_in    = 3'd0;
         end else begin
            pl_in    = close_len;
            phase_in = PH_PAYLOAD;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_ID;
         fc_ff       <= 3'd0;
         position_ff <= 32'h0;
         pl_ff       <= 32'h0;
         ident_ff    <= 32'h0;
         flen_ff     <= 32'h0;
         enc_ff      <= 8'h0;
      end else if (step) begin
         phase_ff    <= phase_in;
         fc_ff       <= fc_in;
         position_ff <= position_in;
         pl_ff       <= pl_in;
         ident_ff    <= ident_in;
         flen_ff     <= flen_in;
         enc_ff      <= enc_in;
      end
   end

   assign result.role          = role;
   assign result.byte_out      = b;
   assign result.frame_ident   = ident_in;
   assign result.frame_length  = flen_in;
   assign result.text_encoding = enc_in;
   assign result.end_of_frame  = eof;
   assign result.error_code    = err;

endmodule

// File: rtl/id3v2_frame_deframer_core.sv
`timescale 1ns / 1ps
// id3v2 frame deframer: one role-tagged result per tag body byte, at one byte
// per clock. A byte is taken into an input register, parsed combinationally
// against the frame state and placed in the result register, and a new byte
// is accepted every cycle while results are taken; the per-byte state update
// with its 33-bit tag bound compare sets the clock rate.
// Depends on id3df_pkg, id3df_csr and id3df_parse.

module id3v2_frame_deframer_core (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [7:0]                   req_tdata,   // byte_in
   input  logic                         req_tuser,   // first_byte
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   // byte_out[7:0], frame_ident[39:8], frame_length[71:40],
   // text_encoding[79:72], error_code[81:80], zero fill[87:82]
   output logic [87:0]                  rsp_tdata,
   output logic [2:0]                   rsp_tuser,   // role
   output logic                         rsp_tlast,   // end_of_frame
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [id3df_pkg::ADDR_W-1:0] csr_paddr,
   input  logic [31:0]                  csr_pwdata,
   output logic [31:0]                  csr_prdata,
   output logic                         csr_pready
);

   id3df_pkg::cfg_type    cfg;
   id3df_pkg::item_type   in_item_ff, in_item_in;
   id3df_pkg::result_type result, rsp_ff, rsp_in;
   logic                  in_valid_ff, in_valid_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  step, req_take;

   id3df_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   id3df_parse u_parse (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .cfg    (cfg),
      .item   (in_item_ff),
      .result (result)
   );

   assign step       = in_valid_ff & (~rsp_valid_ff | rsp_tready);
   assign req_tready = ~in_valid_ff | step;
   assign req_take   = req_tvalid & req_tready;

   always_comb begin
      in_item_in.byte_in    = req_tdata;
      in_item_in.first_byte = req_tuser;
      in_valid_in  = req_take ? 1'b1 : (step ? 1'b0 : in_valid_ff);
      rsp_in       = result;
      rsp_valid_in = step ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_item_ff <= in_item_in;
      end
      if (step) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ff.role;
   assign rsp_tlast  = rsp_ff.end_of_frame;
   assign rsp_tdata  = {6'h0, rsp_ff.error_code, rsp_ff.text_encoding,
                        rsp_ff.frame_length, rsp_ff.frame_ident, rsp_ff.byte_out};

`ifndef ASSERT_OFF
   a_hdr_err_trail: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[81:80] == id3df_pkg::ERR_HEADER)
         |-> (rsp_tuser == id3df_pkg::ROLE_TRAIL))
      else $error("header error on a byte that is not trailing");

   a_eof_role: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tlast)
         |-> (rsp_tuser == id3df_pkg::ROLE_SIZE || rsp_tuser == id3df_pkg::ROLE_FLAGS ||
              rsp_tuser == id3df_pkg::ROLE_ENC || rsp_tuser == id3df_pkg::ROLE_PAYLOAD))
      else $error("end of frame on a byte outside size, flags, encoding or payload");

   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && rsp_tvalid && !rsp_tready) |-> !req_tready)
      else $error("byte accepted while both stages are full and stalled");

   a_step_fills: assert property (@(posedge clock) disable iff (reset)
      step |=> rsp_tvalid)
      else $error("parsed byte did not reach the result register");
`endif

endmodule
